>>> rtl/double_ended_queue_with_cursor_assert.svh
// assertion macros for the double-ended queue with cursor
`ifndef DOUBLE_ENDED_QUEUE_WITH_CURSOR_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_WITH_CURSOR_ASSERT_SVH

`ifndef SYNTHESIS
`define DEQC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DEQC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DEQC_ASSERT(lbl, clk, rst_n, prop, msg)
`define DEQC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/deqc_pkg.sv
// shared constants, command and status codes and result type for the deque
package deqc_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int WORD_BITS_DEF = 32;

    localparam int CMD_BITS = 3;
    localparam int OUT_BITS = 32;
    localparam int ST_BITS  = 2;
    localparam int OCC_BITS = 9;

    localparam logic [CMD_BITS-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_CUR_FRONT  = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_CUR_BACK   = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_CUR_NEXT   = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_CUR_PREV   = 3'd7;

    localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [ST_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_BITS-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] popped_word;
        logic [ST_BITS-1:0]         status;
        logic [OCC_BITS-1:0]        occupancy;
        logic                       cursor_valid;
        logic signed [OUT_BITS-1:0] cursor_word;
    } t_result;

endpackage

>>> rtl/deqc_ram.sv
// ring store: one write port, one read port with registered read data
module deqc_ram #(
    parameter int DEPTH     = 256,
    parameter int WORD_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WORD_BITS-1:0]       i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WORD_BITS-1:0]       o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/deqc_ctrl.sv
// pointer, count and cursor control with ring store access sequencing
`include "double_ended_queue_with_cursor_assert.svh"

module deqc_ctrl #(
    parameter int DEPTH     = 256,
    parameter int WORD_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [2:0]                 i_cmd,
    input  logic signed [31:0]         i_push_word,
    input  logic                       i_out_free,
    output logic                       o_res_load,
    output deqc_pkg::t_result          o_res,
    output logic                       o_mem_we,
    output logic [$clog2(DEPTH)-1:0]   o_mem_waddr,
    output logic [WORD_BITS-1:0]       o_mem_wdata,
    output logic                       o_mem_re,
    output logic [$clog2(DEPTH)-1:0]   o_mem_raddr,
    input  logic [WORD_BITS-1:0]       i_mem_rdata
);

    import deqc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    typedef enum logic {S_IDLE, S_READ} t_state;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_front, n_front;
    logic [AW-1:0]        r_back, n_back;
    logic [AW-1:0]        r_cur, n_cur;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_live, n_live;
    logic [ST_BITS-1:0]   r_status, n_status;
    logic                 r_rd_pop, n_rd_pop;
    logic                 r_rd_cur, n_rd_cur;
    logic [OUT_BITS-1:0]  r_cur_word, n_cur_word;

    logic                 accept;
    logic                 is_full;
    logic                 is_empty;
    logic [AW-1:0]        back_last;
    logic [63:0]          push_ext;
    logic [OUT_BITS-1:0]  rd_word;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
        return (s == '0) ? LAST_SLOT : s - AW'(1);
    endfunction

    function automatic logic [OUT_BITS-1:0] word_out(input logic [WORD_BITS-1:0] w);
        logic [63:0] t;
        t = 64'(signed'(w));
        return t[OUT_BITS-1:0];
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign is_full    = (r_count == FULL_CNT);
    assign is_empty   = (r_count == '0);
    assign back_last  = slot_dec(r_back);
    assign push_ext   = {32'b0, i_push_word};
    assign rd_word    = word_out(i_mem_rdata);

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_back      = r_back;
        n_cur       = r_cur;
        n_count     = r_count;
        n_live      = r_live;
        n_status    = r_status;
        n_rd_pop    = r_rd_pop;
        n_rd_cur    = r_rd_cur;
        n_cur_word  = r_cur_word;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_back;
        o_mem_wdata = push_ext[WORD_BITS-1:0];
        o_mem_re    = 1'b0;
        o_mem_raddr = r_front;
        o_res_load  = 1'b0;

        if (accept) begin
            n_state  = S_READ;
            n_status = ST_OK;
            n_rd_pop = 1'b0;
            n_rd_cur = 1'b0;
            case (i_cmd)
                CMD_PUSH_BACK: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_back;
                        n_back      = slot_inc(r_back);
                        n_count     = r_count + CW'(1);
                    end
                end
                CMD_PUSH_FRONT: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = slot_dec(r_front);
                        n_front     = slot_dec(r_front);
                        n_count     = r_count + CW'(1);
                    end
                end
                CMD_POP_BACK: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_back      = back_last;
                        o_mem_re    = 1'b1;
                        o_mem_raddr = back_last;
                        n_rd_pop    = 1'b1;
                        n_count     = r_count - CW'(1);
                        if (r_live && r_cur == back_last) begin
                            n_live = 1'b0;
                        end
                    end
                end
                CMD_POP_FRONT: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_front     = slot_inc(r_front);
                        o_mem_re    = 1'b1;
                        o_mem_raddr = r_front;
                        n_rd_pop    = 1'b1;
                        n_count     = r_count - CW'(1);
                        if (r_live && r_cur == r_front) begin
                            n_live = 1'b0;
                        end
                    end
                end
                CMD_CUR_FRONT: begin
                    n_live = !is_empty;
                    if (!is_empty) begin
                        n_cur       = r_front;
                        o_mem_re    = 1'b1;
                        o_mem_raddr = r_front;
                        n_rd_cur    = 1'b1;
                    end
                end
                CMD_CUR_BACK: begin
                    n_live = !is_empty;
                    if (!is_empty) begin
                        n_cur       = back_last;
                        o_mem_re    = 1'b1;
                        o_mem_raddr = back_last;
                        n_rd_cur    = 1'b1;
                    end
                end
                CMD_CUR_NEXT: begin
                    if (r_live) begin
                        if (r_cur == back_last) begin
                            n_live = 1'b0;
                        end else begin
                            n_cur       = slot_inc(r_cur);
                            o_mem_re    = 1'b1;
                            o_mem_raddr = slot_inc(r_cur);
                            n_rd_cur    = 1'b1;
                        end
                    end
                end
                default: begin
                    if (r_live) begin
                        if (r_cur == r_front) begin
                            n_live = 1'b0;
                        end else begin
                            n_cur       = slot_dec(r_cur);
                            o_mem_re    = 1'b1;
                            o_mem_raddr = slot_dec(r_cur);
                            n_rd_cur    = 1'b1;
                        end
                    end
                end
            endcase
        end else if (r_state == S_READ && i_out_free) begin
            o_res_load = 1'b1;
            n_state    = S_IDLE;
            if (r_rd_cur) begin
                n_cur_word = rd_word;
            end
        end
    end

    always_comb begin
        o_res.popped_word  = r_rd_pop ? signed'(rd_word) : '0;
        o_res.status       = r_status;
        o_res.occupancy    = OCC_BITS'(r_count);
        o_res.cursor_valid = r_live;
        if (!r_live) begin
            o_res.cursor_word = '0;
        end else if (r_rd_cur) begin
            o_res.cursor_word = signed'(rd_word);
        end else begin
            o_res.cursor_word = signed'(r_cur_word);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= '0;
            r_back   <= '0;
            r_cur    <= '0;
            r_count  <= '0;
            r_live   <= 1'b0;
            r_rd_pop <= 1'b0;
            r_rd_cur <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_front    <= n_front;
            r_back     <= n_back;
            r_cur      <= n_cur;
            r_count    <= n_count;
            r_live     <= n_live;
            r_status   <= n_status;
            r_rd_pop   <= n_rd_pop;
            r_rd_cur   <= n_rd_cur;
            r_cur_word <= n_cur_word;
        end
    end

    `DEQC_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT, "count above depth")
    `DEQC_ASSERT(a_live_nonempty, i_clk, i_rst_n, r_live |-> (r_count != '0), "cursor live on empty queue")
    `DEQC_ASSERT(a_pop_dec, i_clk, i_rst_n, (accept && (i_cmd == CMD_POP_BACK || i_cmd == CMD_POP_FRONT) && !is_empty) |=> (r_count == $past(r_count) - CW'(1)), "pop did not shrink count")
    `DEQC_ASSERT(a_push_inc, i_clk, i_rst_n, (accept && (i_cmd == CMD_PUSH_BACK || i_cmd == CMD_PUSH_FRONT) && !is_full) |=> (r_count == $past(r_count) + CW'(1)), "push did not grow count")
    `DEQC_ASSERT(a_single_access, i_clk, i_rst_n, !(o_mem_we && o_mem_re), "read and write in one command")

endmodule

>>> rtl/double_ended_queue_with_cursor.sv
// a result beat is registered: an accepted command moves the controller to its read state, and the
// result register loads from there once it is free; a new command is taken only when the controller is idle
// the result register lets the next command in while a result waits to be taken
// reset (synchronous, active low) clears pointers, count, cursor and valid flags
// ring store contents are not cleared: only written entries are ever read
module double_ended_queue_with_cursor #(
    parameter int DEPTH     = deqc_pkg::DEPTH_DEF,
    parameter int WORD_BITS = deqc_pkg::WORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_cmd,
    input  logic signed [31:0]  i_push_word,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_popped_word,
    output logic [1:0]          o_status,
    output logic [8:0]          o_occupancy,
    output logic                o_cursor_valid,
    output logic signed [31:0]  o_cursor_word
);

    import deqc_pkg::*;

    localparam int AW = $clog2(DEPTH);

    // ring store port signals
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    // controller to result register
    t_result              res;
    logic                 res_load;
    logic                 out_free;

    // result register
    t_result              r_out;
    logic                 r_out_valid;

    // free when empty or being drained this cycle
    assign out_free = !r_out_valid || i_out_ready;

    deqc_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_push_word (i_push_word),
        .i_out_free  (out_free),
        .o_res_load  (res_load),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    deqc_ram #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // result beat register: valid is control, payload loads without reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_load) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_word  = r_out.popped_word;
    assign o_status       = r_out.status;
    assign o_occupancy    = r_out.occupancy;
    assign o_cursor_valid = r_out.cursor_valid;
    assign o_cursor_word  = r_out.cursor_word;

endmodule

>>> bench/double_ended_queue_with_cursor_test.sv
// self-checking bench for the double-ended queue with cursor: directed script, then random traffic
module double_ended_queue_with_cursor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import deqc_pkg::*;

    localparam int SLOTS        = DEPTH_DEF;
    localparam int SLOT_BITS    = $clog2(SLOTS);
    localparam int SCRIPT_ROWS  = 25;
    localparam int RANDOM_ITEMS = 1600;
    localparam int QUIET_TAIL   = 200;     // final beats run with no idling on either side
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 8;       // margin after the last result beat is taken
    localparam int REPORT_LIMIT = 10;

    localparam logic signed [OUT_BITS-1:0] W_MAX = 32'sh7fff_ffff;
    localparam logic signed [OUT_BITS-1:0] W_MIN = 32'sh8000_0000;
    localparam logic signed [OUT_BITS-1:0] W_ONES = '1;

    // traffic flavours for the random segments
    typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_WALK, MIX_ANY} t_mix;
    typedef enum logic [1:0] {KIND_PUSH, KIND_POP, KIND_PLACE, KIND_STEP} t_kind;

    // one row of the directed script; want is only used where typed is set
    typedef struct packed {
        logic [CMD_BITS-1:0]        cmd;
        logic signed [OUT_BITS-1:0] word;
        logic                       typed;
        t_result                    want;
    } t_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [CMD_BITS-1:0]        i_cmd;
    logic signed [OUT_BITS-1:0] i_push_word;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic signed [OUT_BITS-1:0] o_popped_word;
    logic [ST_BITS-1:0]         o_status;
    logic [OCC_BITS-1:0]        o_occupancy;
    logic                       o_cursor_valid;
    logic signed [OUT_BITS-1:0] o_cursor_word;

    double_ended_queue_with_cursor uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_push_word    (i_push_word),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_popped_word  (o_popped_word),
        .o_status       (o_status),
        .o_occupancy    (o_occupancy),
        .o_cursor_valid (o_cursor_valid),
        .o_cursor_word  (o_cursor_word)
    );

    // shadow copy of the deque: ring of words, end pointers, count and cursor
    logic signed [OUT_BITS-1:0] shadow_words [SLOTS];
    logic [SLOT_BITS-1:0]       front_slot;
    logic [SLOT_BITS-1:0]       back_slot;      // slot just past the back word
    logic [SLOT_BITS-1:0]       cursor_slot;
    logic [OCC_BITS-1:0]        word_count;
    logic                       cursor_on;

    // results predicted for accepted command beats, oldest first
    t_result pending_results [$];

    t_row script [SCRIPT_ROWS];

    int  items_sent    = 0;
    int  results_seen  = 0;
    int  fail_count    = 0;
    int  full_hits     = 0;
    int  empty_hits    = 0;
    int  cursor_runoff = 0;
    int  peak_count    = 0;
    int  cycle_count   = 0;
    bit  quiet_tail    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case a handshake never completes
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [SLOT_BITS-1:0] slot_after(input logic [SLOT_BITS-1:0] s);
        return (int'(s) == SLOTS - 1) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SLOT_BITS-1:0] slot_before(input logic [SLOT_BITS-1:0] s);
        return (s == '0) ? SLOT_BITS'(SLOTS - 1) : s - 1'b1;
    endfunction

    // advance the shadow deque by one command and return the result it should report
    function automatic t_result deque_apply(input logic [CMD_BITS-1:0]        cmd,
                                            input logic signed [OUT_BITS-1:0] word);
        t_result              r;
        logic [SLOT_BITS-1:0] gone;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (int'(word_count) >= SLOTS) begin
                    // full: refused, nothing moves
                    r.status = ST_FULL;
                    full_hits++;
                end else if (cmd == CMD_PUSH_BACK) begin
                    shadow_words[back_slot] = word;
                    back_slot = slot_after(back_slot);
                    word_count++;
                end else begin
                    front_slot = slot_before(front_slot);
                    shadow_words[front_slot] = word;
                    word_count++;
                end
            end
            CMD_POP_BACK, CMD_POP_FRONT: begin
                if (word_count == '0) begin
                    r.status = ST_EMPTY;
                    empty_hits++;
                end else begin
                    if (cmd == CMD_POP_BACK) begin
                        back_slot = slot_before(back_slot);
                        gone = back_slot;
                    end else begin
                        gone = front_slot;
                        front_slot = slot_after(front_slot);
                    end
                    r.popped_word = shadow_words[gone];
                    word_count--;
                    // popping the word under the cursor drops the cursor
                    if (cursor_on && cursor_slot == gone) cursor_on = 1'b0;
                end
            end
            CMD_CUR_FRONT: begin
                cursor_on = (word_count != '0);
                if (cursor_on) cursor_slot = front_slot;
            end
            CMD_CUR_BACK: begin
                cursor_on = (word_count != '0);
                if (cursor_on) cursor_slot = slot_before(back_slot);
            end
            CMD_CUR_NEXT: begin
                if (cursor_on) begin
                    if (cursor_slot == slot_before(back_slot)) begin
                        cursor_on = 1'b0;
                        cursor_runoff++;
                    end else begin
                        cursor_slot = slot_after(cursor_slot);
                    end
                end
            end
            CMD_CUR_PREV: begin
                if (cursor_on) begin
                    if (cursor_slot == front_slot) begin
                        cursor_on = 1'b0;
                        cursor_runoff++;
                    end else begin
                        cursor_slot = slot_before(cursor_slot);
                    end
                end
            end
            default: ;
        endcase
        if (int'(word_count) > peak_count) peak_count = word_count;
        r.occupancy    = word_count;
        r.cursor_valid = cursor_on;
        r.cursor_word  = cursor_on ? shadow_words[cursor_slot] : '0;
        return r;
    endfunction

    function automatic t_result outcome(input logic signed [OUT_BITS-1:0] popped,
                                        input logic [ST_BITS-1:0]         st,
                                        input int                         occ,
                                        input logic                       cv,
                                        input logic signed [OUT_BITS-1:0] cw);
        t_result r;
        r.popped_word  = popped;
        r.status       = st;
        r.occupancy    = OCC_BITS'(occ);
        r.cursor_valid = cv;
        r.cursor_word  = cw;
        return r;
    endfunction

    // weighted command choice per traffic flavour
    function automatic logic [CMD_BITS-1:0] pick_cmd(input t_mix mix);
        int    roll;
        t_kind kind;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  kind = (roll < 75) ? KIND_PUSH : (roll < 82) ? KIND_POP :
                              (roll < 90) ? KIND_PLACE : KIND_STEP;
            MIX_DRAIN: kind = (roll < 8)  ? KIND_PUSH : (roll < 80) ? KIND_POP :
                              (roll < 88) ? KIND_PLACE : KIND_STEP;
            MIX_WALK:  kind = (roll < 20) ? KIND_PUSH : (roll < 30) ? KIND_POP :
                              (roll < 45) ? KIND_PLACE : KIND_STEP;
            default:   kind = t_kind'(roll / 25);
        endcase
        case (kind)
            KIND_PUSH:  return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            KIND_POP:   return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
            KIND_PLACE: return $urandom_range(0, 1) ? CMD_CUR_BACK : CMD_CUR_FRONT;
            default:    return $urandom_range(0, 1) ? CMD_CUR_PREV : CMD_CUR_NEXT;
        endcase
    endfunction

    // mostly full-range words, with the corner values now and then
    function automatic logic signed [OUT_BITS-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return W_ONES;
            2:       return W_MAX;
            3:       return W_MIN;
            default: return $urandom;
        endcase
    endfunction

    // drive one command beat, hold it until taken, then log what should come back
    task automatic send_command(input logic [CMD_BITS-1:0]        cmd,
                                input logic signed [OUT_BITS-1:0] word,
                                input logic                       typed,
                                input t_result                    want);
        t_result predicted;
        quiet_tail = (items_sent >= SCRIPT_ROWS + RANDOM_ITEMS - QUIET_TAIL);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_push_word <= word;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // shadow state always moves on; typed rows override the expectation only
        predicted = deque_apply(cmd, word);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // sender backs off until every outstanding result has been taken
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic check_result();
        t_result want;
        results_seen++;
        if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("unexpected result beat at cycle %0d: popped %h status %0d occ %0d",
                         cycle_count, o_popped_word, o_status, o_occupancy);
            return;
        end
        want = pending_results.pop_front();
        if (o_popped_word !== want.popped_word || o_status !== want.status ||
            o_occupancy !== want.occupancy || o_cursor_valid !== want.cursor_valid ||
            o_cursor_word !== want.cursor_word) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("result %0d mismatch (expected/actual): popped %h/%h status %0d/%0d",
                         results_seen, want.popped_word, o_popped_word,
                         want.status, o_status);
                $display("    occ %0d/%0d cursor %b/%b word %h/%h",
                         want.occupancy, o_occupancy,
                         want.cursor_valid, o_cursor_valid, want.cursor_word, o_cursor_word);
            end
        end
    endtask

    // result side: check each taken beat, stall ready in short random bursts
    initial begin
        int stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) check_result();
            if (stall_left == 0 && !quiet_tail && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 3);
            if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // command side: reset, directed script, forced fill and drain, random segments
    initial begin
        t_mix mix;
        int   seg_len;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_cmd       <= CMD_PUSH_BACK;
        i_push_word <= '0;

        front_slot  = '0;
        back_slot   = '0;
        cursor_slot = '0;
        word_count  = '0;
        cursor_on   = 1'b0;

        // empty-queue corners first, then a four-word deque of extreme values
        // (front to back: 0, min, max, -1) walked with the cursor and taken apart
        script[0]  = '{CMD_POP_BACK,   32'sh1234_5678, 1'b1, outcome('0, ST_EMPTY, 0, 0, '0)};
        script[1]  = '{CMD_POP_FRONT,  32'sh1234_5678, 1'b1, outcome('0, ST_EMPTY, 0, 0, '0)};
        script[2]  = '{CMD_CUR_FRONT,  '0,     1'b1, outcome('0, ST_OK, 0, 0, '0)};
        script[3]  = '{CMD_CUR_BACK,   '0,     1'b1, outcome('0, ST_OK, 0, 0, '0)};
        script[4]  = '{CMD_CUR_NEXT,   '0,     1'b1, outcome('0, ST_OK, 0, 0, '0)};
        script[5]  = '{CMD_CUR_PREV,   W_ONES, 1'b1, outcome('0, ST_OK, 0, 0, '0)};
        script[6]  = '{CMD_PUSH_BACK,  W_MAX,  1'b1, outcome('0, ST_OK, 1, 0, '0)};
        script[7]  = '{CMD_PUSH_FRONT, W_MIN,  1'b1, outcome('0, ST_OK, 2, 0, '0)};
        script[8]  = '{CMD_PUSH_BACK,  W_ONES, 1'b1, outcome('0, ST_OK, 3, 0, '0)};
        script[9]  = '{CMD_PUSH_FRONT, '0,     1'b1, outcome('0, ST_OK, 4, 0, '0)};
        script[10] = '{CMD_CUR_FRONT,  '0,     1'b1, outcome('0, ST_OK, 4, 1, '0)};
        script[11] = '{CMD_CUR_NEXT,   '0,     1'b0, '0};
        script[12] = '{CMD_CUR_NEXT,   '0,     1'b0, '0};
        script[13] = '{CMD_CUR_NEXT,   '0,     1'b0, '0};
        // stepping off the back end
        script[14] = '{CMD_CUR_NEXT,   '0,     1'b1, outcome('0, ST_OK, 4, 0, '0)};
        script[15] = '{CMD_CUR_BACK,   '0,     1'b1, outcome('0, ST_OK, 4, 1, W_ONES)};
        script[16] = '{CMD_CUR_PREV,   '0,     1'b0, '0};
        // pop behind the cursor keeps it, popping its own word drops it
        script[17] = '{CMD_POP_BACK,   '0,     1'b1, outcome(W_ONES, ST_OK, 3, 1, W_MAX)};
        script[18] = '{CMD_POP_BACK,   '0,     1'b1, outcome(W_MAX, ST_OK, 2, 0, '0)};
        script[19] = '{CMD_CUR_FRONT,  '0,     1'b0, '0};
        // stepping off the front end
        script[20] = '{CMD_CUR_PREV,   '0,     1'b1, outcome('0, ST_OK, 2, 0, '0)};
        script[21] = '{CMD_CUR_BACK,   '0,     1'b0, '0};
        script[22] = '{CMD_POP_FRONT,  W_MAX,  1'b1, outcome('0, ST_OK, 1, 1, W_MIN)};
        script[23] = '{CMD_POP_FRONT,  '0,     1'b1, outcome(W_MIN, ST_OK, 0, 0, '0)};
        script[24] = '{CMD_PUSH_BACK,  32'sh5555_aaaa, 1'b0, '0};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k])
            send_command(script[k].cmd, script[k].word, script[k].typed, script[k].want);
        hold_until_drained();

        // fill right up, then knock on the full queue a few times
        while (int'(word_count) < SLOTS) send_command(pick_cmd(MIX_FILL), pick_word(), 1'b0, '0);
        repeat (4) send_command($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                                pick_word(), 1'b0, '0);
        repeat (6) send_command(pick_cmd(MIX_WALK), pick_word(), 1'b0, '0);

        // and back down to empty, then pop the empty queue
        while (word_count != '0) send_command(pick_cmd(MIX_DRAIN), pick_word(), 1'b0, '0);
        repeat (4) send_command($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK,
                                pick_word(), 1'b0, '0);

        // random segments of varying flavour, the occasional full back-off between them
        while (items_sent < SCRIPT_ROWS + RANDOM_ITEMS) begin
            mix     = t_mix'($urandom_range(0, 3));
            seg_len = $urandom_range(20, 120);
            if (items_sent < SCRIPT_ROWS + RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 7) == 0)
                hold_until_drained();
            for (int n = 0; n < seg_len && items_sent < SCRIPT_ROWS + RANDOM_ITEMS; n++)
                send_command(pick_cmd(mix), pick_word(), 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d commands and %0d result beats; %0d refused pushes, %0d empty pops",
                 items_sent, results_seen, full_hits, empty_hits);
        $display("deepest fill %0d of %0d words, cursor ran off an end %0d times",
                 peak_count, SLOTS, cursor_runoff);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
